FILE: sv/pba_pkg.sv
package pba_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY     = 2'd2;

    localparam logic [31:0] INC_RESET  = 32'd39370534;
    localparam logic [15:0] DUTY_RESET = 16'd32768;

    // datapath widths
    localparam int SAMPLE_W = 24;
    localparam int ACC_W    = 28;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 32;
    localparam int QUOT_W   = 20;

    typedef enum logic [2:0] {
        W_SINE       = 3'd0,
        W_PULSE      = 3'd1,
        W_PULSE_BLEP = 3'd2,
        W_TRI_BLEP   = 3'd3,
        W_TRI        = 3'd4,
        W_SAW        = 3'd5,
        W_SAW_BLEP   = 3'd6
    } t_wave;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BASE,
        S_BSETUP,
        S_BDIV,
        S_BSQ,
        S_BACC,
        S_TMUL,
        S_TY,
        S_TLEAK,
        S_TMEM,
        S_SPOS,
        S_SRDA,
        S_SRDB,
        S_SMUL,
        S_SADD,
        S_DONE
    } t_state;

endpackage

FILE: sv/pba_mul.sv
module pba_mul
    import pba_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: sv/pba_div.sv
module pba_div
    import pba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_den, n_den;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [DIV_W-1:0]  rem2;
    logic              fits;

    // numerator is always below the divisor, so the remainder stays under 2^31
    assign rem2 = {r_rem[DIV_W-2:0], 1'b0};
    assign fits = rem2 >= r_den;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = fits ? rem2 - r_den : rem2;
            n_quot = {r_quot[QUOT_W-2:0], fits};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: sv/pba_rom.sv
module pba_rom
    import pba_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                                 i_clk,
    input  logic [$clog2(SINE_TABLE_SIZE)-1:0]   i_addr,
    output logic signed [SAMPLE_W-1:0]           o_data
);

    localparam logic [63:0] ONE30       = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin of a Q0.32 phase, Q20, taylor series on the first quadrant
    function automatic logic signed [SAMPLE_W-1:0] sine_q20(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        r  = {34'd0, p[29:0]};
        q  = p[30] ? ONE30 - r : r;
        x  = (q * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE30 - x2 / 64'd110;
        t  = ONE30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE30 - ((x2 * t) >> 30) / 64'd6;
        s  = (((x * t) >> 30) + 64'd512) >> 10;
        return p[31] ? -SAMPLE_W'(s) : SAMPLE_W'(s);
    endfunction

    logic signed [SAMPLE_W-1:0] w_rom [SINE_TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] r_data;

    for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_entry
        localparam logic [63:0] POS = 64'(g) << 32;
        localparam logic [31:0] PH  = 32'(POS / SINE_TABLE_SIZE);
        localparam logic signed [SAMPLE_W-1:0] VAL = sine_q20(PH);
        assign w_rom[g] = VAL;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: sv/polyblep_audio_oscillator.sv
// channel  | direction | handshake                      | payload
// tick     | in        | i_tick_valid / o_tick_stall    | i_tick
// sample   | out       | o_sample_valid / i_sample_stall | o_sample
// config   | in        | i_cfg_we                       | i_cfg_idx, i_cfg_data
//
// naive shapes go from S_BASE straight to S_DONE; the interpolated sine adds S_SPOS, S_SRDA,
// S_SRDB, S_SMUL and S_SADD; each blep term that fires runs the shared 20-step restoring divider,
// and a term that does not fire only passes through S_BSETUP
// stall is held high from acceptance until the sample enters the output register
// a full output register holds the finished sample until the sink takes it
// reset is synchronous; the sine table is constant and needs no fill
module polyblep_audio_oscillator
    import pba_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick_valid,
    output logic                       o_tick_stall,
    input  logic                       i_tick,
    output logic                       o_sample_valid,
    input  logic                       i_sample_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(SINE_TABLE_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_TABLE_SIZE - 1);

    localparam logic signed [ACC_W-1:0]  ACC_ONE  = ACC_W'(1 << QUOT_W);
    localparam logic signed [ACC_W-1:0]  ACC_SMAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]  ACC_SMIN = ACC_W'(-(1 << (SAMPLE_W - 1)));
    localparam logic signed [MUL_W-1:0]  LEAK_Q30 = 34'sd1063004406;
    localparam logic signed [37:0]       MEM_MAX  = 38'sd2147483647;
    localparam logic signed [37:0]       MEM_MIN  = -38'sd2147483648;

    t_state r_state, n_state;

    t_wave       r_waveform;
    logic [31:0] r_inc;
    logic [15:0] r_duty;

    logic [31:0]               r_phase, n_phase;
    logic signed [31:0]        r_mem, n_mem;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [MUL_W-1:0]   r_y, n_y;
    logic                      r_k, n_k;
    logic                      r_neg, n_neg;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [31:0]               r_frac, n_frac;
    logic signed [SAMPLE_W-1:0] r_a, n_a;
    logic signed [SAMPLE_W-1:0] r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      div_start, div_done;
    logic [QUOT_W-1:0]         div_quot;
    logic [IDX_W-1:0]          rom_addr, rom_next;
    logic signed [SAMPLE_W-1:0] rom_data;

    logic                      inc_pos;
    logic [31:0]               duty32;
    logic                      pulse_hi, tri_hi;
    logic signed [21:0]        lin, lin_abs;
    logic signed [22:0]        tri_naive;
    logic [31:0]               blep_off, blep_t, blep_num;
    logic                      blep_lo, blep_hi;
    logic [QUOT_W:0]           blep_v;
    logic [QUOT_W:0]           blep_sq;
    logic                      out_free;
    t_state                    post_blep;
    logic signed [MUL_W-1:0]   tri_d;
    logic signed [37:0]        leak;

    pba_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (blep_num),
        .i_den   (r_inc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    pba_rom #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign inc_pos   = !r_inc[31] && (r_inc != '0);
    assign duty32    = {r_duty, 16'h0000};
    assign pulse_hi  = {1'b0, r_phase} > (33'h1_0000_0000 - {1'b0, duty32});
    assign tri_hi    = r_phase > 32'h8000_0000;
    assign lin       = $signed({1'b0, r_phase[31:11]}) - 22'sd1048576;
    assign lin_abs   = lin[21] ? -lin : lin;
    assign tri_naive = $signed({lin_abs, 1'b0}) - 23'sd1048576;

    // first term sits on the rising edge, second on the phase wrap
    assign blep_off = (r_waveform == W_TRI_BLEP) ? 32'h8000_0000 : duty32;
    assign blep_t   = r_k ? r_phase : r_phase + blep_off;
    assign blep_lo  = inc_pos && (blep_t < r_inc);
    assign blep_hi  = inc_pos && (({1'b0, blep_t} + {1'b0, r_inc}) > 33'h1_0000_0000);
    assign blep_num = blep_lo ? blep_t : 32'd0 - blep_t;
    assign blep_v   = (QUOT_W + 1)'(1 << QUOT_W) - {1'b0, div_quot};
    assign blep_sq  = mul_p[2*QUOT_W:QUOT_W];

    assign post_blep = !r_k ? S_BSETUP : ((r_waveform == W_TRI_BLEP) ? S_TMUL : S_DONE);

    assign tri_d = (MUL_W'(r_acc) <<< 8) - MUL_W'(r_mem);
    assign leak  = $signed(mul_p[PROD_W-1:30]);

    assign rom_next = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    assign out_free = !r_out_valid || !i_sample_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_tick_valid && i_tick) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                unique case (r_waveform) inside
                    W_SINE:                             n_state = S_SPOS;
                    W_PULSE_BLEP, W_TRI_BLEP, W_SAW_BLEP: n_state = S_BSETUP;
                    default:                            n_state = S_DONE;
                endcase
            end
            S_BSETUP: n_state = (blep_lo || blep_hi) ? S_BDIV : post_blep;
            S_BDIV: begin
                if (div_done) begin
                    n_state = S_BSQ;
                end
            end
            S_BSQ:   n_state = S_BACC;
            S_BACC:  n_state = post_blep;
            S_TMUL:  n_state = S_TY;
            S_TY:    n_state = S_TLEAK;
            S_TLEAK: n_state = S_TMEM;
            S_TMEM:  n_state = S_DONE;
            S_SPOS:  n_state = S_SRDA;
            S_SRDA:  n_state = S_SRDB;
            S_SRDB:  n_state = S_SMUL;
            S_SMUL:  n_state = S_SADD;
            S_SADD:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_phase     = r_phase;
        n_mem       = r_mem;
        n_acc       = r_acc;
        n_y         = r_y;
        n_k         = r_k;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_frac      = r_frac;
        n_a         = r_a;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_sample_stall;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        rom_addr    = r_idx;
        unique case (r_state)
            S_BASE: begin
                n_k = (r_waveform == W_SAW_BLEP);
                unique case (r_waveform) inside
                    W_PULSE, W_PULSE_BLEP: n_acc = pulse_hi ? ACC_ONE : -ACC_ONE;
                    W_TRI_BLEP:            n_acc = tri_hi ? ACC_ONE : -ACC_ONE;
                    W_TRI:                 n_acc = ACC_W'(tri_naive);
                    W_SAW, W_SAW_BLEP:     n_acc = ACC_W'(lin);
                    default:               n_acc = '0;
                endcase
            end
            S_BSETUP: begin
                // the first term is added, the second subtracted
                n_neg     = blep_lo ^ r_k;
                div_start = blep_lo || blep_hi;
                if (!(blep_lo || blep_hi)) begin
                    n_k = 1'b1;
                end
            end
            S_BSQ: begin
                mul_a = MUL_W'(blep_v);
                mul_b = MUL_W'(blep_v);
            end
            S_BACC: begin
                n_acc = r_neg ? r_acc - ACC_W'(blep_sq) : r_acc + ACC_W'(blep_sq);
                n_k   = 1'b1;
            end
            S_TMUL: begin
                mul_a = MUL_W'($signed(r_inc));
                mul_b = tri_d;
            end
            S_TY: begin
                n_y = MUL_W'(r_mem) + MUL_W'($signed(mul_p[PROD_W-1:32]));
            end
            S_TLEAK: begin
                mul_a = r_y;
                mul_b = LEAK_Q30;
            end
            S_TMEM: begin
                if (leak > MEM_MAX) begin
                    n_mem = 32'sh7fff_ffff;
                end else if (leak < MEM_MIN) begin
                    n_mem = -32'sh8000_0000;
                end else begin
                    n_mem = 32'(leak);
                end
                n_acc = ACC_W'(r_y >>> 6);
            end
            S_SPOS: begin
                mul_a = MUL_W'(r_phase);
                mul_b = MUL_W'(SINE_TABLE_SIZE);
            end
            S_SRDA: begin
                rom_addr = mul_p[32 +: IDX_W];
                n_idx    = mul_p[32 +: IDX_W];
                n_frac   = mul_p[31:0];
            end
            S_SRDB: begin
                rom_addr = rom_next;
                n_a      = rom_data;
            end
            S_SMUL: begin
                mul_a = MUL_W'(rom_data) - MUL_W'(r_a);
                mul_b = MUL_W'(r_frac);
            end
            S_SADD: begin
                n_acc = ACC_W'(r_a) + ACC_W'($signed(mul_p[PROD_W-1:32]));
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_phase     = r_phase + r_inc;
                    if (r_acc > ACC_SMAX) begin
                        n_out = SAMPLE_W'(ACC_SMAX);
                    end else if (r_acc < ACC_SMIN) begin
                        n_out = SAMPLE_W'(ACC_SMIN);
                    end else begin
                        n_out = SAMPLE_W'(r_acc);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_mem       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_mem       <= n_mem;
        end
        r_acc  <= n_acc;
        r_y    <= n_y;
        r_k    <= n_k;
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_frac <= n_frac;
        r_a    <= n_a;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= W_SINE;
            r_inc      <= INC_RESET;
            r_duty     <= DUTY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAVEFORM: r_waveform <= t_wave'(i_cfg_data[2:0]);
                CFG_INC:      r_inc      <= i_cfg_data[31:0];
                CFG_DUTY:     r_duty     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_tick_stall   = r_state != S_IDLE;
    assign o_sample_valid = r_out_valid;
    assign o_sample       = r_out;

endmodule

FILE: sim/testbench.sv
module testbench;
    import pba_pkg::*;

    localparam int TABLE_N        = 1024;
    localparam int TOTAL_ITEMS    = 1350;
    localparam int SETTLE_CYCLES  = 80;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam longint TIMEOUT_UNITS = 5000000;

    localparam longint          ONE20       = 64'sd1 <<< 20;
    localparam longint unsigned ONE30U      = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          LEAK_Q30    = 64'sd1063004406;
    localparam longint          I32_MAX     = (64'sd1 <<< 31) - 1;
    localparam longint          I32_MIN     = -(64'sd1 <<< 31);
    localparam longint          SMP_MAX     = (64'sd1 <<< 23) - 1;
    localparam longint          SMP_MIN     = -(64'sd1 <<< 23);
    localparam logic [2:0]      W_UNUSED    = 3'd7;

    typedef enum {CHK_OK, CHK_BAD, CHK_EXTRA} t_chk;

    class sample_scoreboard;
        logic [SAMPLE_W-1:0] pending_samples[$];
        logic [31:0]         phase_acc;
        logic signed [31:0]  leak_mem;
        logic [2:0]          wave_sel;
        logic [31:0]         inc_reg;
        logic [15:0]         duty_reg;
        longint              sine_tab[TABLE_N];

        function new();
            for (int k = 0; k < TABLE_N; k++)
                sine_tab[k] = sine_poly(32'((longint'(k) << 32) / TABLE_N));
            phase_acc = '0;
            leak_mem  = '0;
            wave_sel  = W_SINE;
            inc_reg   = INC_RESET;
            duty_reg  = DUTY_RESET;
        endfunction

        // taylor series of sin over a quarter cycle, mirrored by quadrant
        function longint sine_poly(logic [31:0] p);
            longint unsigned r, q, x, x2, t, s;
            r  = {34'd0, p[29:0]};
            q  = p[30] ? (ONE30U - r) : r;
            x  = (q * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = ONE30U - x2 / 110;
            t  = ONE30U - ((x2 * t) >> 30) / 72;
            t  = ONE30U - ((x2 * t) >> 30) / 42;
            t  = ONE30U - ((x2 * t) >> 30) / 20;
            t  = ONE30U - ((x2 * t) >> 30) / 6;
            s  = (((x * t) >> 30) + 512) >> 10;
            return p[31] ? -longint'(s) : longint'(s);
        endfunction

        function longint sine_interp(logic [31:0] p);
            longint unsigned pos;
            int unsigned     idx, nxt;
            longint          a, b, frac;
            pos  = 64'(p);
            pos  = pos * TABLE_N;
            idx  = 32'(pos >> 32);
            nxt  = (idx + 1 >= TABLE_N) ? 0 : idx + 1;
            a    = sine_tab[idx];
            b    = sine_tab[nxt];
            frac = pos & 64'hFFFF_FFFF;
            return a + (((b - a) * frac) >>> 32);
        endfunction

        // two-sample polynomial residual around a wrap of t
        function longint blep_res(logic [31:0] t, longint dt);
            longint unsigned tt, dtu, v, rem;
            if (dt <= 0) return 0;
            tt  = 64'(t);
            dtu = dt;
            if (longint'(tt) < dt) begin
                v = (64'd1 << 20) - ((tt << 20) / dtu);
                return -longint'((v * v) >> 20);
            end
            if (tt + dtu > (64'd1 << 32)) begin
                rem = (64'd1 << 32) - tt;
                v   = (64'd1 << 20) - ((rem << 20) / dtu);
                return longint'((v * v) >> 20);
            end
            return 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_WAVEFORM)
                wave_sel = data[2:0];
            else if (idx == CFG_INC)
                inc_reg = data;
            else if (idx == CFG_DUTY)
                duty_reg = data[15:0];
        endfunction

        function void note_tick(logic t);
            longint      inc, lin, val, x, prev, y, lk;
            logic [31:0] duty32;
            if (!t) return;
            inc    = longint'($signed(inc_reg));
            duty32 = {duty_reg, 16'd0};
            lin    = longint'(phase_acc[31:11]);
            lin    = lin - ONE20;
            case (wave_sel)
                W_SINE: val = sine_interp(phase_acc);
                W_PULSE, W_PULSE_BLEP: begin
                    val = ({32'd0, phase_acc} > ((64'd1 << 32) - {32'd0, duty32})) ?
                          ONE20 : -ONE20;
                    if (wave_sel == W_PULSE_BLEP)
                        val += blep_res(phase_acc + duty32, inc) - blep_res(phase_acc, inc);
                end
                W_TRI_BLEP: begin
                    x = (phase_acc > 32'h8000_0000) ? ONE20 : -ONE20;
                    x += blep_res(phase_acc + 32'h8000_0000, inc) - blep_res(phase_acc, inc);
                    prev = leak_mem;
                    y  = prev + ((inc * x * 256 - inc * prev) >>> 32);
                    lk = (y * LEAK_Q30) >>> 30;
                    if (lk > I32_MAX)
                        lk = I32_MAX;
                    else if (lk < I32_MIN)
                        lk = I32_MIN;
                    leak_mem = lk[31:0];
                    val = y >>> 6;
                end
                W_TRI:      val = 2 * (lin < 0 ? -lin : lin) - ONE20;
                W_SAW:      val = lin;
                W_SAW_BLEP: val = lin - blep_res(phase_acc, inc);
                default:    val = 0;
            endcase
            phase_acc += inc_reg;
            if (val > SMP_MAX)
                val = SMP_MAX;
            else if (val < SMP_MIN)
                val = SMP_MIN;
            pending_samples.push_back(val[SAMPLE_W-1:0]);
        endfunction

        function t_chk check_sample(logic [SAMPLE_W-1:0] got,
                                    output logic [SAMPLE_W-1:0] want);
            want = '0;
            if (pending_samples.size() == 0) return CHK_EXTRA;
            want = pending_samples.pop_front();
            return (got === want) ? CHK_OK : CHK_BAD;
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_tick_valid;
    logic                       o_tick_stall;
    logic                       i_tick;
    logic                       o_sample_valid;
    logic                       i_sample_stall;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    sample_scoreboard    sb;
    logic [SAMPLE_W-1:0] want;
    int                  error_count = 0;
    int                  items_sent  = 0;
    int                  low_ticks   = 0;
    int                  samples_seen = 0;
    int                  reg_writes  = 0;
    int                  phase_no    = 0;
    int                  hold_request = 0;
    bit                  steady      = 1'b0;
    bit [7:0]            waves_seen  = '0;

    polyblep_audio_oscillator #(
        .SINE_TABLE_SIZE(TABLE_N)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_valid  (i_tick_valid),
        .o_tick_stall  (o_tick_stall),
        .i_tick        (i_tick),
        .o_sample_valid(o_sample_valid),
        .i_sample_stall(i_sample_stall),
        .o_sample      (o_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // generous bound on the length of the whole run
    initial begin
        #(TIMEOUT_UNITS);
        $display("simulation failed");
        $finish;
    end

    task automatic report_error(input string what);
        error_count++;
        $display("ERROR: %s", what);
    endtask

    // results are checked before a new tick is noted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_sample_valid && !i_sample_stall) begin
            samples_seen++;
            case (sb.check_sample(o_sample, want))
                CHK_BAD: report_error($sformatf("sample %0d: got %0d, predicted %0d",
                                                samples_seen, o_sample, $signed(want)));
                CHK_EXTRA: report_error($sformatf("sample %0d (%0d) with none predicted",
                                                  samples_seen, o_sample));
                default: ;
            endcase
        end
        if (i_rst_n && i_tick_valid && !o_tick_stall)
            sb.note_tick(i_tick);
    end

    // sample sink: random hold-off per transaction unless steady, plus one long hold in the third random phase
    initial begin : sample_sink
        int gap;
        i_sample_stall <= 1'b1;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_request > 0) begin
                i_sample_stall <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_sample_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_sample_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_sample_valid) @(posedge i_clk);
        end
    end

    task automatic send_tick(input logic t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_tick_valid <= 1'b1;
        i_tick       <= t;
        @(posedge i_clk);
        while (o_tick_stall) @(posedge i_clk);
        if (t)
            items_sent++;
        else
            low_ticks++;
    endtask

    task automatic wait_empty();
        i_tick_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // a low tick gives no sample, so let the block settle before any write
    task automatic drain_and_settle();
        wait_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        if (idx == CFG_WAVEFORM)
            waves_seen[data[2:0]] = 1'b1;
        reg_writes++;
    endtask

    task automatic configure(input logic [2:0] w, input logic [31:0] inc,
                             input logic [15:0] duty);
        write_reg(CFG_WAVEFORM, {29'd0, w});
        write_reg(CFG_INC, inc);
        write_reg(CFG_DUTY, {16'd0, duty});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0000_0000;
                   3: return 32'h0000_0001;
                   default: return 32'hFFFF_FFFF;
               endcase
            1, 2:    return $urandom_range(0, 32'h00FF_FFFF);
            3, 4, 5: return $urandom_range(32'h0100_0000, 32'h4000_0000);
            6:       return 32'd1 << $urandom_range(0, 31);
            7:       return -$urandom_range(1, 32'h4000_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin : stimulus
        int len;
        sb = new();
        i_rst_n      <= 1'b0;
        i_tick_valid <= 1'b0;
        i_tick       <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_WAVEFORM;
        i_cfg_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, then each shape at corner settings
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_and_settle();
        configure(W_PULSE, 32'h2000_0000, 16'hFFFF);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        configure(W_PULSE_BLEP, 32'h1000_0000, 16'h0000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        // negative increment: residuals vanish
        configure(W_PULSE_BLEP, 32'h8000_0000, 16'h8000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        // negative increment makes the integrator run away into saturation
        configure(W_TRI_BLEP, 32'h8000_0000, 16'h8000);
        repeat (5) send_tick(1'b1);
        drain_and_settle();
        configure(W_TRI_BLEP, 32'h7FFF_FFFF, 16'h8000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        configure(W_TRI, 32'h0000_0000, 16'h4000);
        send_tick(1'b1);
        drain_and_settle();
        configure(W_SAW, 32'hFFFF_FFFF, 16'h4000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        configure(W_SAW_BLEP, 32'h7FFF_FFFF, 16'h4000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        configure(W_UNUSED, 32'h0123_4567, 16'h4000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();
        configure(W_SINE, 32'h0400_0000, 16'h8000);
        repeat (2) send_tick(1'b1);
        drain_and_settle();

        // random phases, each with its own settings
        while (items_sent < TOTAL_ITEMS) begin
            phase_no++;
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_WAVEFORM, {29'd0, 3'($urandom_range(0, 7))});
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_INC, pick_increment());
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_DUTY, {16'd0, pick_duty()});
            i_cfg_we <= 1'b0;
            len = $urandom_range(10, 50);
            if (phase_no == 3) begin
                steady       = 1'b0;
                hold_request = LONG_HOLD;
                len          = 40;
            end
            for (int n = 0; n < len; n++) begin
                if (phase_no == 5 && n == len / 2)
                    wait_empty();
                send_tick($urandom_range(0, 15) != 0);
            end
            drain_and_settle();
        end

        i_tick_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            report_error($sformatf("%0d predicted samples never arrived", sb.pending()));

        $display("run: %0d ticks plus %0d idle ticks, %0d samples, %0d random phases",
                 items_sent, low_ticks, samples_seen, phase_no);
        $display("run: %0d register writes, waveform codes used %b, %0d errors",
                 reg_writes, waves_seen, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
